[rtl/mfs_pkg.sv]
// Package for the message FIFO with search: operation and status codes,
// and the command record that passes from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2,
    OP_CLR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned SrcW = 16;
  localparam int unsigned MsgW = 32;
  localparam int unsigned TotW = 32;

  typedef struct packed {
    op_e             op;
    logic [SrcW-1:0] src;
    logic [MsgW-1:0] msg;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/message_fifo_with_search.sv]
// Message FIFO with search, top level. The back-end sequencer executes one
// command at a time and walks the store one entry per cycle during a search,
// while the front end keeps accepting items into its queue until it is full.
// Reset (rst_ni, asynchronous, active low) empties the queue and clears the
// pointers and both running counters; the entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module message_fifo_with_search import mfs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [SrcW-1:0]               source_i,
  input  wire logic signed [MsgW-1:0]        message_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [SrcW-1:0]                    out_source_o,
  output logic signed [MsgW-1:0]             out_message_o,
  output logic [TotW-1:0]                    enqueue_total_o,
  output logic [TotW-1:0]                    dequeue_total_o,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy_o
);

  // The front end takes items into a two-entry command queue. It keeps
  // accepting while the back end is busy walking the store or waiting for
  // its result to be taken, so the two sides stall independently.
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  mfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .source_i    (source_i),
    .message_i   (message_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // The back end owns the circular entry store, the head and tail pointers,
  // the occupancy and the wrapping enqueue and dequeue counters. A search
  // reads one entry per cycle from oldest to newest and stops at the first
  // match. Each command yields exactly one item, held in the result register
  // until the downstream side takes it.
  mfs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_take_o      (cmd_take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_source_o    (out_source_o),
    .out_message_o   (out_message_o),
    .enqueue_total_o (enqueue_total_o),
    .dequeue_total_o (dequeue_total_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

`default_nettype wire

[rtl/mfs_front.sv]
// Front end of the message FIFO with search: accepts input items, decodes
// the operation and holds commands in a two-entry queue for the back end.
// Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_front import mfs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             operation_i,
  input  wire logic [SrcW-1:0]        source_i,
  input  wire logic signed [MsgW-1:0] message_i,
  output logic                        cmd_valid_o,
  output cmd_t                        cmd_o,
  input  wire logic                   cmd_take_i
);

  cmd_t       slot_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       in_cmd;

  // Stall depends on the queue fill only, never on the incoming valid.
  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = cmd_take_i && cmd_valid_o;

  always_comb begin
    in_cmd.op  = op_e'(operation_i);
    in_cmd.src = source_i;
    in_cmd.msg = message_i;
  end

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/mfs_back.sv]
// Back end of the message FIFO with search: entry memory, pointers, running
// counters, the sequencer that executes commands and the result register.
// Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_back import mfs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire cmd_t                          cmd_i,
  output logic                               cmd_take_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [SrcW-1:0]                    out_source_o,
  output logic signed [MsgW-1:0]             out_message_o,
  output logic [TotW-1:0]                    enqueue_total_o,
  output logic [TotW-1:0]                    dequeue_total_o,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SRCH = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] idx);
    nxt = (idx == IdxW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [SrcW-1:0] src_mem [DEPTH];
  logic [MsgW-1:0] msg_mem [DEPTH];
  logic [SrcW-1:0] rd_src_q;
  logic [MsgW-1:0] rd_msg_q;

  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [TotW-1:0] enq_q, enq_d;
  logic [TotW-1:0] deq_q, deq_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] left_q, left_d;
  logic            rvld_q, rvld_d;
  status_e         status_q, status_d;
  logic [SrcW-1:0] src_q, src_d;
  logic [MsgW-1:0] msg_q, msg_d;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] rd_addr;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    enq_d      = enq_q;
    deq_d      = deq_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    rvld_d     = 1'b0;
    status_d   = status_q;
    src_d      = src_q;
    msg_d      = msg_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_addr    = head_q;
    cmd_take_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          src_d      = '0;
          msg_d      = '0;
          status_d   = ST_OK;
          state_d    = S_RESP;
          unique case (cmd_i.op)
            OP_ENQ: begin
              if (count_q == CntW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                tail_d  = nxt(tail_q);
                count_d = count_q + 1'b1;
                enq_d   = enq_q + 1'b1;
              end
            end
            OP_DEQ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                head_d  = nxt(head_q);
                count_d = count_q - 1'b1;
                deq_d   = deq_q + 1'b1;
                state_d = S_DEQ;
              end
            end
            OP_SRCH: begin
              msg_d    = cmd_i.msg;
              status_d = ST_EMPTY;
              left_d   = count_q;
              ptr_d    = head_q;
              state_d  = S_SRCH;
            end
            OP_CLR: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              enq_d   = '0;
              deq_d   = '0;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_DEQ: begin
        src_d   = rd_src_q;
        msg_d   = rd_msg_q;
        state_d = S_RESP;
      end
      S_SRCH: begin
        rd_addr = ptr_q;
        if (rvld_q && (rd_msg_q == msg_q)) begin
          status_d = ST_OK;
          src_d    = rd_src_q;
          state_d  = S_RESP;
        end else if (left_q == '0) begin
          if (!rvld_q) begin
            state_d = S_RESP;
          end
        end else begin
          mem_re = 1'b1;
          rvld_d = 1'b1;
          ptr_d  = nxt(ptr_q);
          left_d = left_q - 1'b1;
        end
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      enq_q   <= '0;
      deq_q   <= '0;
      ptr_q   <= '0;
      left_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      enq_q   <= enq_d;
      deq_q   <= deq_d;
      ptr_q   <= ptr_d;
      left_q  <= left_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    src_q    <= src_d;
    msg_q    <= msg_d;
  end

  // Entry memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      src_mem[tail_q] <= cmd_i.src;
      msg_mem[tail_q] <= cmd_i.msg;
    end
    if (mem_re) begin
      rd_src_q <= src_mem[rd_addr];
      rd_msg_q <= msg_mem[rd_addr];
    end
  end

  assign out_valid_o     = (state_q == S_RESP);
  assign status_o        = status_q;
  assign out_source_o    = src_q;
  assign out_message_o   = msg_q;
  assign enqueue_total_o = enq_q;
  assign dequeue_total_o = deq_q;
  assign occupancy_o     = count_q;

endmodule

`default_nettype wire
